// ----- hw/rtl/bvfm_pkg.sv -----
// bvfm_pkg: shared widths, scaling constants, register indexes and the scaled-sample struct
// used by the bus voltage fail monitor; no dependencies
package bvfm_pkg;

    localparam int RAW_W  = 10;
    localparam int MV_W   = 12;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 7;
    localparam int THR_W  = 12;
    localparam int DWELL_W = 16;

    // full adc code, the divisor of the millivolt scaling
    localparam int ADC_MAX_CODE = 1023;

    // floor(p / 1023) == (p * RECIP_M) >> RECIP_SHIFT for every p below 2^22
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 23;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(ADC_MAX_CODE) - 64'd1) / 64'(ADC_MAX_CODE);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);
    localparam int MUL_W = RECIP_SHIFT + MV_W;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FAIL_THR    = 2'd0,
        CFG_RETURN_THR  = 2'd1,
        CFG_FAIL_TIME   = 2'd2,
        CFG_RETURN_TIME = 2'd3
    } cfg_idx_t;

    // one sample after scaling, on its way to the tracking stage
    typedef struct packed {
        logic              valid;
        logic              used;
        logic [MV_W-1:0]   mv;
        logic [TIME_W-1:0] now;
    } scaled_t;

endpackage

// ----- hw/rtl/bvfm_scale.sv -----
// bvfm_scale: three-stage pipeline that qualifies a sample and scales it to mV
// depends on bvfm_pkg
module bvfm_scale
    import bvfm_pkg::*;
#(
    parameter int FULL_SCALE_MV = 3405
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              conv_done,
    input  logic              conv_overrun,
    input  logic [RAW_W-1:0]  raw_sample,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              down_ready,
    output scaled_t           scaled
);

    localparam int FS_W   = $clog2(FULL_SCALE_MV + 1);
    localparam int PROD_W = RAW_W + FS_W;
    localparam logic [FS_W-1:0] FULL_SCALE = FS_W'(FULL_SCALE_MV);

    logic              a_valid_reg;
    logic              a_used_reg;
    logic [RAW_W-1:0]  a_raw_reg;
    logic [TIME_W-1:0] a_now_reg;

    logic              b_valid_reg;
    logic              b_used_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [TIME_W-1:0] b_now_reg;

    logic              c_valid_reg;
    logic              c_used_reg;
    logic [MV_W-1:0]   c_mv_reg;
    logic [TIME_W-1:0] c_now_reg;

    logic              adv_a;
    logic              adv_b;
    logic              adv_c;
    logic [PROD_W-1:0] b_prod_next;
    logic [MUL_W-1:0]  quot_full;
    logic [MV_W-1:0]   c_mv_next;

    // a stage moves when it is empty or its successor moves
    assign adv_c    = !c_valid_reg || down_ready;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    assign b_prod_next = {{FS_W{1'b0}}, a_raw_reg} * {{RAW_W{1'b0}}, FULL_SCALE};
    assign quot_full   = MUL_W'(b_prod_reg) * MUL_W'(RECIP_M);
    assign c_mv_next   = quot_full[MUL_W-1:RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (adv_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_used_reg <= conv_done && !conv_overrun;
            a_raw_reg  <= raw_sample;
            a_now_reg  <= now_ms;
        end
        if (adv_b)
        begin
            b_used_reg <= a_used_reg;
            b_prod_reg <= b_prod_next;
            b_now_reg  <= a_now_reg;
        end
        if (adv_c)
        begin
            c_used_reg <= b_used_reg;
            c_mv_reg   <= c_mv_next;
            c_now_reg  <= b_now_reg;
        end
    end

    assign scaled.valid = c_valid_reg;
    assign scaled.used  = c_used_reg;
    assign scaled.mv    = c_mv_reg;
    assign scaled.now   = c_now_reg;

endmodule

// ----- hw/rtl/bus_voltage_fail_monitor_top.sv -----
// bus_voltage_fail_monitor_top: undervoltage detector with a running mean (each
// sample averaged with the last mean), hysteresis thresholds and dwell timers;
// depends on bvfm_pkg and bvfm_scale; a transaction passes the input, product and
//   quotient stages of bvfm_scale, then into the output register
// throughput: one transaction per cycle unless m_tready stalls; the mean, timers
//   and state update in the single output stage, so consecutive samples chain there each cycle
// reset: rst_n clears the pipeline, the mean, sample count, both timers and
//   the state (unknown), and loads the threshold and dwell registers with defaults
module bus_voltage_fail_monitor_top
    import bvfm_pkg::*;
#(
    parameter int WARMUP_SAMPLES = 100,
    parameter int FULL_SCALE_MV  = 3405
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_sample[9:0], now_ms[41:10], zero pad
    input  logic [1:0]  s_tuser,   // conv_done[0], conv_overrun[1]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample_used[0], mean_mv[12:1], mean_valid[13],
                                   // bus_state[15:14], bus_failed[16],
                                   // fail_event[17], return_event[18], zero pad
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_OK      = 2'd1,
        ST_FAILED  = 2'd2
    } mon_state_t;

    localparam logic [CNT_W-1:0] WARMUP = CNT_W'(WARMUP_SAMPLES);

    // configuration
    logic [THR_W-1:0]   fail_thr_reg;
    logic [THR_W-1:0]   return_thr_reg;
    logic [DWELL_W-1:0] fail_time_reg;
    logic [DWELL_W-1:0] return_time_reg;

    // tracking state
    logic [CNT_W-1:0]   count_reg;
    logic [MV_W-1:0]    mean_reg;
    logic [TIME_W-1:0]  low_since_reg;
    logic [TIME_W-1:0]  high_since_reg;
    mon_state_t         state_reg;

    logic [CNT_W-1:0]   count_next;
    logic [MV_W-1:0]    mean_next;
    logic [TIME_W-1:0]  low_since_next;
    logic [TIME_W-1:0]  high_since_next;
    mon_state_t         state_next;
    logic               fail_ev_next;
    logic               return_ev_next;

    // output register
    logic               m_tvalid_reg;
    logic               used_reg;
    logic [MV_W-1:0]    mean_mv_reg;
    logic               mean_valid_reg;
    mon_state_t         bus_state_reg;
    logic               bus_failed_reg;
    logic               fail_ev_reg;
    logic               return_ev_reg;

    scaled_t            scaled;
    logic               out_ready;
    logic               load_out;
    logic [MV_W:0]      mean_sum;
    logic [TIME_W-1:0]  low_elapsed;
    logic [TIME_W-1:0]  high_elapsed;

    // output register is free when empty or being drained this cycle
    assign out_ready = !m_tvalid_reg || m_tready;
    assign load_out  = scaled.valid && out_ready;

    bvfm_scale #(
        .FULL_SCALE_MV (FULL_SCALE_MV)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .conv_done    (s_tuser[0]),
        .conv_overrun (s_tuser[1]),
        .raw_sample   (s_tdata[9:0]),
        .now_ms       (s_tdata[41:10]),
        .down_ready   (out_ready),
        .scaled       (scaled)
    );

    assign mean_sum     = {1'b0, mean_reg} + {1'b0, scaled.mv};
    assign low_elapsed  = scaled.now - low_since_reg;
    assign high_elapsed = scaled.now - high_since_reg;

    // one sample's update of mean, warm-up count, dwell timers and state
    always_comb
    begin
        count_next      = count_reg;
        mean_next       = mean_reg;
        low_since_next  = low_since_reg;
        high_since_next = high_since_reg;
        state_next      = state_reg;
        fail_ev_next    = 1'b0;
        return_ev_next  = 1'b0;
        if (load_out && scaled.used)
        begin
            // first sample seeds the mean
            if (count_reg == '0)
            begin
                mean_next = scaled.mv;
            end
            else
            begin
                mean_next = mean_sum[MV_W:1];
            end
            if (count_reg < WARMUP)
            begin
                count_next = count_reg + 1'b1;
            end
            if (count_next >= WARMUP)
            begin
                if (mean_next <= fail_thr_reg)
                begin
                    high_since_next = '0;
                    // zero means not started; a stamp ahead of now means wrap
                    if (low_since_reg == '0 || scaled.now < low_since_reg)
                    begin
                        low_since_next = scaled.now;
                    end
                    else if (state_reg != ST_FAILED &&
                             {{(TIME_W-DWELL_W){1'b0}}, fail_time_reg} <= low_elapsed)
                    begin
                        state_next   = ST_FAILED;
                        fail_ev_next = 1'b1;
                    end
                end
                else if (mean_next > return_thr_reg)
                begin
                    low_since_next = '0;
                    if (high_since_reg == '0 || scaled.now < high_since_reg)
                    begin
                        high_since_next = scaled.now;
                    end
                    else if (state_reg != ST_OK &&
                             {{(TIME_W-DWELL_W){1'b0}}, return_time_reg} <= high_elapsed)
                    begin
                        // leaving unknown for ok is silent
                        return_ev_next = (state_reg != ST_UNKNOWN);
                        state_next     = ST_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_thr_reg    <= THR_W'(1903);
            return_thr_reg  <= THR_W'(1996);
            fail_time_reg   <= DWELL_W'(20);
            return_time_reg <= DWELL_W'(1500);
            count_reg       <= '0;
            mean_reg        <= '0;
            low_since_reg   <= '0;
            high_since_reg  <= '0;
            state_reg       <= ST_UNKNOWN;
            m_tvalid_reg    <= 1'b0;
            used_reg        <= 1'b0;
            mean_mv_reg     <= '0;
            mean_valid_reg  <= 1'b0;
            bus_state_reg   <= ST_UNKNOWN;
            bus_failed_reg  <= 1'b1;
            fail_ev_reg     <= 1'b0;
            return_ev_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FAIL_THR:    fail_thr_reg    <= cfg_data[THR_W-1:0];
                    CFG_RETURN_THR:  return_thr_reg  <= cfg_data[THR_W-1:0];
                    CFG_FAIL_TIME:   fail_time_reg   <= cfg_data;
                    CFG_RETURN_TIME: return_time_reg <= cfg_data;
                    default:         ;
                endcase
            end

            count_reg      <= count_next;
            mean_reg       <= mean_next;
            low_since_reg  <= low_since_next;
            high_since_reg <= high_since_next;
            state_reg      <= state_next;

            if (load_out)
            begin
                m_tvalid_reg   <= 1'b1;
                used_reg       <= scaled.used;
                mean_mv_reg    <= mean_next;
                mean_valid_reg <= (count_next != '0);
                bus_state_reg  <= state_next;
                bus_failed_reg <= (state_next != ST_OK);
                fail_ev_reg    <= fail_ev_next;
                return_ev_reg  <= return_ev_next;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, return_ev_reg, fail_ev_reg, bus_failed_reg, bus_state_reg,
                       mean_valid_reg, mean_mv_reg, used_reg};

    // a fail event always shows the failed state
    a_fail_event_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && fail_ev_reg |-> bus_state_reg == ST_FAILED)
        else $error("fail event without failed state");

    // a return event always shows the ok state
    a_return_event_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && return_ev_reg |-> bus_state_reg == ST_OK && !bus_failed_reg)
        else $error("return event without ok state");

    // a dropped sample never raises an event
    a_drop_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !used_reg |-> !fail_ev_reg && !return_ev_reg)
        else $error("event on dropped sample");

    // once a sample is taken the count never falls back to zero
    a_count_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |=> count_reg != '0)
        else $error("sample count returned to zero");

endmodule
